// ===== rtl/core/sorted_max_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_max_priority_queue assertion macros
// Shorthand for the concurrent checks of the sorted max priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define SMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define SMQ_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Types and constants shared by the sorted max priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 64;
  localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]  CAP_RESET  = 7'd64;
  localparam logic [DATA_W-1:0] EMPTY_DATA = 32'h7FFF_FFFF;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } smq_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } smq_status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } smq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/smq_cell.sv =====
// ----------------------------------------------------------------------------
// smq_cell
// One slot of the sorted chain: holds one value, compares it with the
// incoming word and picks its next value from itself, its neighbors or the
// incoming word.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_cell
  import smq_pkg::*;
(
  input  wire logic                     clk,
  input  wire smq_ctl_t                 ctl,
  input  wire logic                     occ_i,        // slot holds a live entry
  input  wire logic                     left_ge_i,    // new word goes above left slot
  input  wire logic signed [DATA_W-1:0] left_data_i,
  input  wire logic signed [DATA_W-1:0] right_data_i,
  output logic                          ge_o,
  output logic signed [DATA_W-1:0]      data_o
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // chain is descending from slot 0, so ge is a thermometer along it
  assign ge_o   = !occ_i || (ctl.value >= data_r);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.enq && ge_o) begin
      data_nxt = left_ge_i ? left_data_i : ctl.value;
    end else if (ctl.deq) begin
      data_nxt = right_data_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Max priority queue held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each input word is an enqueue or a dequeue; every word gives exactly one
// result word, registered, so a result appears the cycle after its word is
// taken. One word is accepted every cycle while the result side keeps up: the
// rate is set by the cell chain, where every cell settles its next value from
// its own compare with the incoming word and its left neighbor's compare, and
// the whole row moves together. Equal values leave newest first. An enqueue
// into a full queue (occupancy at or above min(capacity, DEPTH)) is dropped
// with status full; a dequeue from an empty queue returns 0x7FFFFFFF with
// status empty. Capacity is taken on the cfg channel and resets to 64; the
// user must write it only while the queue is idle; the block does not check.
`default_nettype none

module sorted_max_priority_queue
  import smq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // [31:0] value
  input  wire logic                   in_tuser,   // [0] cmd
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] data, [38:32] occupancy
  output logic [STATUS_W-1:0]         out_tuser,  // [1:0] status
  // capacity register
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data
);

  logic [CNT_W-1:0]          cap_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]         out_data_r, out_data_nxt;
  logic [CNT_W-1:0]          out_occ_r;
  smq_status_t               out_status_r, out_status_nxt;

  logic                      accept;
  logic                      is_deq;
  logic                      full;
  logic                      empty;
  smq_ctl_t                  ctl;

  logic signed [DATA_W-1:0]  cell_data [DEPTH];
  logic                      cell_ge   [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_deq    = (in_tuser == CMD_DEQ);

  assign empty = (count_r == '0);
  assign full  = (count_r >= cap_r) || (32'(count_r) >= 32'(DEPTH));

  assign ctl.enq   = accept && !is_deq && !full;
  assign ctl.deq   = accept && is_deq && !empty;
  assign ctl.value = in_tdata;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_ge;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_ge   = 1'b0;
      assign left_data = '0;
    end else begin : g_body
      assign left_ge   = cell_ge[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    smq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occ_i        (32'(count_r) > 32'(i)),
      .left_ge_i    (left_ge),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .ge_o         (cell_ge[i]),
      .data_o       (cell_data[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    if (is_deq) begin
      if (empty) begin
        out_data_nxt   = EMPTY_DATA;
        out_status_nxt = ST_EMPTY;
      end else begin
        out_data_nxt = cell_data[0];
        count_nxt    = count_r - CNT_W'(1);
      end
    end else if (full) begin
      out_status_nxt = ST_FULL;
    end else begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_occ_r, out_data_r});
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/smq_checker.sv =====
// ----------------------------------------------------------------------------
// smq_checker
// Port-level checks of the sorted max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_max_priority_queue_macros.svh"

module smq_checker
  import smq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0]    out_tuser
);

  logic [DATA_W-1:0] data_f;
  logic [CNT_W-1:0]  occ_f;

  assign data_f = out_tdata[DATA_W-1:0];
  assign occ_f  = out_tdata[DATA_W+CNT_W-1:DATA_W];

  `SMQ_ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_tvalid, "result valid right after reset")
  `SMQ_ASSERT_IMP(a_stall_hold, clk, rst_n, $past(out_tvalid && !out_tready) && $past(rst_n), $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")
  `SMQ_ASSERT_IMP(a_empty_word, clk, rst_n, out_tvalid && out_tuser == ST_EMPTY, data_f == EMPTY_DATA && occ_f == '0, "empty result carries wrong data or occupancy")
  `SMQ_ASSERT_IMP(a_full_word, clk, rst_n, out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_OK), out_tuser == ST_FULL ? data_f == '0 : 1'b1, "dropped enqueue carries nonzero data")
  `SMQ_ASSERT_IMP(a_occ_bound, clk, rst_n, out_tvalid, 32'(occ_f) <= 32'(DEPTH) && out_tuser != 2'd3, "occupancy beyond depth or bad status")

endmodule

bind sorted_max_priority_queue smq_checker #(
  .DEPTH (DEPTH)
) u_smq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== dv/sorted_max_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_tb
// Self-checking bench for the sorted max priority queue. A clocked driver
// feeds enqueue and dequeue words from a backlog, and a shadow sorted store
// predicts every result word. A monitor checks data, status and occupancy
// against the oldest prediction. Capacity is changed only while the queue is
// idle. Both sides pause at random, and one long result-side hold backs up
// the input.
// ----------------------------------------------------------------------------

module sorted_max_priority_queue_tb;
  import smq_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    smq_cmd_t          cmd;
    logic [DATA_W-1:0] value;
  } queue_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    smq_status_t       status;
    logic [CNT_W-1:0]  occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data = '0;

  queue_op_t     word_backlog[$];
  queue_result_t due_results[$];
  int            shadow_store[$];  // ascending, largest at the back
  logic [CNT_W-1:0] cap_reg = CAP_RESET;

  int  words_queued = 0;
  int  words_taken = 0;
  int  errors = 0;
  int  cycle_count = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  long_stall_go = 1'b0;
  bit  in_fired = 1'b0;
  bit  out_fired = 1'b0;

  int  enq_ok = 0;
  int  enq_dropped = 0;
  int  deq_ok = 0;
  int  deq_empty = 0;
  int  peak_occupancy = 0;
  int  cfg_writes = 0;

  sorted_max_priority_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tuser   (in_tuser),   // [0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] data, [38:32] occupancy
    .out_tuser  (out_tuser),  // [1:0] status
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Shadow of the sorted store: a new value goes above every value not
  // greater than it, a dequeue takes the top.
  function automatic queue_result_t predict_queue_op(smq_cmd_t cmd,
                                                     logic [DATA_W-1:0] value);
    queue_result_t r;
    int            slot;
    int            room;
    int            v;
    r.data   = '0;
    r.status = ST_OK;
    v        = value;
    room     = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    if (cmd == CMD_ENQ) begin
      if (shadow_store.size() >= room) begin
        r.status = ST_FULL;
        enq_dropped++;
      end else begin
        slot = shadow_store.size();
        while (slot > 0 && shadow_store[slot-1] > v) slot--;
        shadow_store.insert(slot, v);
        enq_ok++;
      end
    end else if (shadow_store.size() == 0) begin
      r.data   = EMPTY_DATA;
      r.status = ST_EMPTY;
      deq_empty++;
    end else begin
      r.data = shadow_store.pop_back();
      deq_ok++;
    end
    r.occupancy = CNT_W'(shadow_store.size());
    if (shadow_store.size() > peak_occupancy) peak_occupancy = shadow_store.size();
    return r;
  endfunction

  // Sender: one gap per word, then hold the word until it is taken.
  always @(negedge clk) begin
    queue_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_fired) tx_gap = tx_steady ? 0 : $urandom_range(0, 9);
      if (!in_tvalid || in_fired) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          op = word_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= op.value;
          in_tuser  <= op.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random pause before each word, plus one long hold on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (long_stall_go) begin
        rx_hold = LONG_HOLD;
        long_stall_go = 1'b0;
      end
      if (out_fired) rx_gap = rx_steady ? 0 : $urandom_range(0, 9);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Predict on every accepted input word, check every accepted result word.
  always @(posedge clk) begin
    queue_result_t want;
    in_fired  <= rst_n && in_tvalid && in_tready;
    out_fired <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      due_results.push_back(predict_queue_op(smq_cmd_t'(in_tuser), in_tdata));
      words_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got data %h status %0d occupancy %0d",
                 $time, out_tdata[DATA_W-1:0], out_tuser, out_tdata[DATA_W +: CNT_W]);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.data) begin
          $display("%0t: data mismatch: expected %h, got %h",
                   $time, want.data, out_tdata[DATA_W-1:0]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[DATA_W +: CNT_W] !== want.occupancy) begin
          $display("%0t: occupancy mismatch: expected %0d, got %0d",
                   $time, want.occupancy, out_tdata[DATA_W +: CNT_W]);
          errors++;
        end
      end
    end
  end

  task automatic push_word(input smq_cmd_t cmd, input logic [DATA_W-1:0] value);
    queue_op_t op;
    op.cmd   = cmd;
    op.value = value;
    word_backlog.push_back(op);
    words_queued++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(0, 8) - 4;  // narrow band, many ties
      default: return $urandom();
    endcase
  endfunction

  task automatic random_ops(input int n, input int enq_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < enq_pct) push_word(CMD_ENQ, pick_value());
      else push_word(CMD_DEQ, $urandom());
    end
  endtask

  task automatic shuffle_pacing();
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  // Return at a falling edge once every word is taken and answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (words_taken != words_queued || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cap_reg = cap;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] caps[6];
    caps = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd8, 7'd0};
    caps[5] = CNT_W'($urandom_range(1, 127));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, ties and empty dequeues at the reset capacity
    push_word(CMD_DEQ, $urandom());
    push_word(CMD_ENQ, 32'h7FFF_FFFF);
    push_word(CMD_ENQ, 32'h8000_0000);
    push_word(CMD_ENQ, 32'h0000_0000);
    push_word(CMD_ENQ, 32'hFFFF_FFFF);
    push_word(CMD_ENQ, 32'd5);
    push_word(CMD_ENQ, 32'd5);
    push_word(CMD_ENQ, 32'h8000_0000);
    repeat (8) push_word(CMD_DEQ, $urandom());

    // fill past the reset capacity, then drain
    repeat (66) push_word(CMD_ENQ, pick_value());
    repeat (66) push_word(CMD_DEQ, $urandom());

    // small queue: full drop, then room again after a dequeue
    write_capacity(7'd4);
    push_word(CMD_ENQ, 32'd3);
    push_word(CMD_ENQ, 32'hFFFF_FFFE);
    push_word(CMD_ENQ, 32'd3);
    push_word(CMD_ENQ, 32'd100);
    push_word(CMD_ENQ, 32'd7);
    push_word(CMD_DEQ, $urandom());
    push_word(CMD_ENQ, 32'd7);
    push_word(CMD_ENQ, 32'd8);

    // above DEPTH saturates; fill to the top and overflow
    write_capacity(7'd127);
    repeat (68) push_word(CMD_ENQ, pick_value());
    repeat (70) push_word(CMD_DEQ, $urandom());

    // zero capacity drops every enqueue
    write_capacity(7'd0);
    repeat (3) push_word(CMD_ENQ, pick_value());
    push_word(CMD_DEQ, $urandom());

    // lower capacity below the held count
    write_capacity(7'd20);
    repeat (10) push_word(CMD_ENQ, pick_value());
    write_capacity(7'd3);
    repeat (2) push_word(CMD_ENQ, pick_value());
    repeat (8) push_word(CMD_DEQ, $urandom());
    repeat (2) push_word(CMD_ENQ, pick_value());
    repeat (4) push_word(CMD_DEQ, $urandom());

    // long result-side hold with the sender pushing flat out
    write_capacity(7'd64);
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    long_stall_go = 1'b1;
    random_ops(60, 85);
    wait_idle();

    foreach (caps[i]) begin
      write_capacity(caps[i]);
      shuffle_pacing();
      random_ops(35, 75);
      shuffle_pacing();
      random_ops(35, 30);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (40) push_word(CMD_DEQ, $urandom());
    wait_idle();

    $display("Ran %0d words: %0d enqueues kept, %0d dropped full, %0d dequeues, %0d empty",
             words_taken, enq_ok, enq_dropped, deq_ok, deq_empty);
    $display("Peak occupancy %0d over %0d capacity settings, one %0d-cycle output hold",
             peak_occupancy, cfg_writes, LONG_HOLD);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
